// ===== rtl/fsa_pkg.sv =====
// Shared types, codes and helpers for the fault severity aggregator.
package fsa_pkg;

    localparam int SLOTS = 32;
    localparam int SLOT_W = 5;
    localparam int FUNC_W = 3;
    localparam int ROOM_W = 2;
    localparam int COUNT_W = 6;
    localparam int SEV_MAP_W = 64;
    localparam int CFG_INDEX_W = 1;
    localparam int BYTES = 4;
    localparam int BYTE_CNT_W = 4;

    localparam logic [SEV_MAP_W-1:0] SEVERITY_MAP_RESET = 64'd38;
    localparam logic [SLOTS-1:0] KNOWN_MASK_RESET = 32'd7;

    localparam logic [CFG_INDEX_W-1:0] REG_SEVERITY_MAP = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KNOWN_MASK = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_REPORT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ACK_RESET = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PROCESS = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd4;

    localparam logic [1:0] SEV_WARNING = 2'd0;
    localparam logic [1:0] SEV_ERROR = 2'd1;
    localparam logic [1:0] SEV_CRITICAL = 2'd2;

    localparam logic [ROOM_W-1:0] ROOM_MAX = 2'd2;

    // Post-step snapshot handed from the state stage to the lookup stages
    typedef struct packed {
        logic [SLOTS-1:0]  active_mask;
        logic [SLOTS-1:0]  live;
        logic [SLOT_W-1:0] fault_index;
        logic [SLOT_W-1:0] rank;
        logic              reset_needed;
        logic              error_sent;
        logic              cleared_sent;
    } snap_t;

    typedef logic [BYTES-1:0][BYTE_CNT_W-1:0] byte_cnt_t;

    typedef struct packed {
        snap_t     snap;
        byte_cnt_t cnt;
    } count_stage_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
        logic [SLOT_W-1:0]  fault;
    } rank_res_t;

    function automatic logic [BYTE_CNT_W-1:0] popcount8(input logic [7:0] v);
        logic [BYTE_CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + BYTE_CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

// ===== rtl/fsa_cmd_if.sv =====
// Command channel: valid/ready with one command item.
interface fsa_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [fsa_pkg::FUNC_W-1:0]  func;
    logic [fsa_pkg::SLOT_W-1:0]  fault_index;
    logic [fsa_pkg::SLOT_W-1:0]  rank;
    logic [fsa_pkg::ROOM_W-1:0]  queue_room;

    modport source (output valid, func, fault_index, rank, queue_room, input ready);
    modport sink (input valid, func, fault_index, rank, queue_room, output ready);
endinterface

// ===== rtl/fsa_rsp_if.sv =====
// Response channel: valid/ready with one status item.
interface fsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fsa_pkg::SLOTS-1:0]    active_mask;
    logic                         fault_is_active;
    logic                         any_active;
    logic [fsa_pkg::COUNT_W-1:0]  active_count;
    logic                         rank_found;
    logic [fsa_pkg::SLOT_W-1:0]   rank_fault;
    logic                         reset_needed;
    logic                         error_event_sent;
    logic                         cleared_event_sent;

    modport source (output valid, active_mask, fault_is_active, any_active, active_count,
                    rank_found, rank_fault, reset_needed, error_event_sent,
                    cleared_event_sent, input ready);
    modport sink (input valid, active_mask, fault_is_active, any_active, active_count,
                  rank_found, rank_fault, reset_needed, error_event_sent,
                  cleared_event_sent, output ready);
endinterface

// ===== rtl/fsa_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
interface fsa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fsa_pkg::CFG_INDEX_W-1:0] reg_index;
    logic [fsa_pkg::SEV_MAP_W-1:0]   data;

    modport source (output valid, reg_index, data, input ready);
    modport sink (input valid, reg_index, data, output ready);
endinterface

// ===== rtl/fault_severity_aggregator_unit.sv =====
// Fault severity aggregator: fault mask, severity events and rank lookup.
// Takes one command per clock and returns one response per command. The
// fault state update sets the command rate; the two stages behind it do
// the byte population counts and then the count and rank lookup. Three
// responses can be held while the response side stalls, after which
// cmd.ready drops. Configuration writes are always ready and take effect
// the next cycle.
module fault_severity_aggregator_unit #(
    parameter int NUM_FAULTS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    fsa_cmd_if.sink   cmd,
    fsa_rsp_if.source rsp,
    fsa_cfg_if.sink   cfg
);

    logic                  take;
    logic                  s1_adv, s2_adv, out_adv;
    logic                  s1_valid_reg, s2_valid_reg, out_valid_reg;
    fsa_pkg::snap_t        snap;
    fsa_pkg::snap_t        s1_reg;
    fsa_pkg::count_stage_t s2_reg, s2_next;
    fsa_pkg::rank_res_t    rank_res;

    assign out_adv   = !out_valid_reg || rsp.ready;
    assign s2_adv    = !s2_valid_reg || out_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign cmd.ready = s1_adv;
    assign take      = cmd.valid && s1_adv;

    fsa_state #(
        .NUM_FAULTS (NUM_FAULTS)
    ) u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .take        (take),
        .func        (cmd.func),
        .fault_index (cmd.fault_index),
        .rank        (cmd.rank),
        .queue_room  (cmd.queue_room),
        .snap        (snap)
    );

    always_comb
    begin
        s2_next.snap = s1_reg;
        for (int b = 0; b < fsa_pkg::BYTES; b++)
        begin
            s2_next.cnt[b] = fsa_pkg::popcount8(s1_reg.live[8*b +: 8]);
        end
    end

    fsa_rank u_rank (
        .live (s2_reg.snap.live),
        .rank (s2_reg.snap.rank),
        .cnt  (s2_reg.cnt),
        .res  (rank_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload stages load only on a transfer into them
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= snap;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (out_adv && s2_valid_reg)
        begin
            rsp.active_mask        <= s2_reg.snap.active_mask;
            rsp.fault_is_active    <= s2_reg.snap.active_mask[s2_reg.snap.fault_index];
            rsp.any_active         <= |s2_reg.snap.active_mask;
            rsp.active_count       <= rank_res.count;
            rsp.rank_found         <= rank_res.found;
            rsp.rank_fault         <= rank_res.fault;
            rsp.reset_needed       <= s2_reg.snap.reset_needed;
            rsp.error_event_sent   <= s2_reg.snap.error_sent;
            rsp.cleared_event_sent <= s2_reg.snap.cleared_sent;
        end
    end

    assign rsp.valid = out_valid_reg;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("command side stalled with a free pipeline stage");

    a_rank_hits_active: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.rank_found) |-> rsp.active_mask[rsp.rank_fault])
        else $error("rank lookup returned an inactive slot");

    a_empty_mask_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.any_active) |-> (rsp.active_count == '0 && !rsp.rank_found))
        else $error("count or rank reported with no active fault");

    // Compare against the rank that sat in the count stage when the output loaded
    a_count_bounds_rank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.rank_found ==
                       (rsp.active_count > fsa_pkg::COUNT_W'($past(s2_reg.snap.rank))))
                      || !$past(out_adv && s2_valid_reg))
        else $error("rank found disagrees with active count");
`endif

endmodule

// ===== rtl/fsa_state.sv =====
// Configuration registers, fault state and the per-command state update.
module fsa_state #(
    parameter int NUM_FAULTS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fsa_cfg_if.sink                     cfg,
    input  logic                        take,
    input  logic [fsa_pkg::FUNC_W-1:0]  func,
    input  logic [fsa_pkg::SLOT_W-1:0]  fault_index,
    input  logic [fsa_pkg::SLOT_W-1:0]  rank,
    input  logic [fsa_pkg::ROOM_W-1:0]  queue_room,
    output fsa_pkg::snap_t              snap
);

    localparam logic [fsa_pkg::SLOTS-1:0] SLOT_LIMIT =
        (NUM_FAULTS >= fsa_pkg::SLOTS) ? {fsa_pkg::SLOTS{1'b1}}
                                        : fsa_pkg::SLOTS'((64'd1 << NUM_FAULTS) - 64'd1);

    logic [fsa_pkg::SEV_MAP_W-1:0] severity_map_reg;
    logic [fsa_pkg::SLOTS-1:0]     known_fault_mask_reg;
    logic [fsa_pkg::SLOTS-1:0]     active_bits_reg, active_bits_next;
    logic                          reset_latch_reg, reset_latch_next;
    logic                          error_pending_reg, error_pending_next;
    logic                          cleared_pending_reg, cleared_pending_next;

    logic [fsa_pkg::SLOTS-1:0] known;
    logic [fsa_pkg::SLOTS-1:0] err_class;
    logic [fsa_pkg::SLOTS-1:0] bit_sel;
    logic [1:0]                sev;
    logic                      slot_known;
    logic                      had_error;
    logic                      error_left;
    logic [fsa_pkg::ROOM_W-1:0] room;
    logic [fsa_pkg::ROOM_W-1:0] room_left;
    logic                      error_sent;
    logic                      cleared_sent;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            severity_map_reg     <= fsa_pkg::SEVERITY_MAP_RESET;
            known_fault_mask_reg <= fsa_pkg::KNOWN_MASK_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                fsa_pkg::REG_SEVERITY_MAP: severity_map_reg <= cfg.data;
                fsa_pkg::REG_KNOWN_MASK:   known_fault_mask_reg <= cfg.data[fsa_pkg::SLOTS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int s = 0; s < fsa_pkg::SLOTS; s++)
        begin
            err_class[s] = (severity_map_reg[2*s +: 2] == fsa_pkg::SEV_ERROR) ||
                           (severity_map_reg[2*s +: 2] == fsa_pkg::SEV_CRITICAL);
        end
    end

    assign known      = known_fault_mask_reg & SLOT_LIMIT;
    assign bit_sel    = fsa_pkg::SLOTS'(1) << fault_index;
    assign sev        = severity_map_reg[{fault_index, 1'b0} +: 2];
    assign slot_known = known[fault_index];
    assign had_error  = |(active_bits_reg & known & err_class);
    assign error_left = |(active_bits_reg & ~bit_sel & known & err_class);
    assign room       = (queue_room > fsa_pkg::ROOM_MAX) ? fsa_pkg::ROOM_MAX : queue_room;

    always_comb
    begin
        active_bits_next     = active_bits_reg;
        reset_latch_next     = reset_latch_reg;
        error_pending_next   = error_pending_reg;
        cleared_pending_next = cleared_pending_reg;
        error_sent           = 1'b0;
        cleared_sent         = 1'b0;
        room_left            = room;
        case (func)
            fsa_pkg::FUNC_REPORT:
            begin
                if (slot_known)
                begin
                    active_bits_next = active_bits_reg | bit_sel;
                    if (sev == fsa_pkg::SEV_CRITICAL)
                    begin
                        reset_latch_next = 1'b1;
                    end
                    if (err_class[fault_index] && !had_error)
                    begin
                        error_pending_next = 1'b1;
                    end
                end
            end
            fsa_pkg::FUNC_CLEAR:
            begin
                if (slot_known)
                begin
                    active_bits_next = active_bits_reg & ~bit_sel;
                    if (err_class[fault_index] && !reset_latch_reg && !error_left)
                    begin
                        cleared_pending_next = 1'b1;
                    end
                end
            end
            fsa_pkg::FUNC_ACK_RESET:
            begin
                reset_latch_next = 1'b0;
            end
            fsa_pkg::FUNC_PROCESS:
            begin
                // Error event goes first and takes one slot of room
                if (error_pending_reg && room != '0)
                begin
                    error_pending_next = 1'b0;
                    error_sent         = 1'b1;
                    room_left          = room - fsa_pkg::ROOM_W'(1);
                end
                if (cleared_pending_reg && room_left != '0)
                begin
                    cleared_pending_next = 1'b0;
                    cleared_sent         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bits_reg     <= '0;
            reset_latch_reg     <= 1'b0;
            error_pending_reg   <= 1'b0;
            cleared_pending_reg <= 1'b0;
        end
        else if (take)
        begin
            active_bits_reg     <= active_bits_next;
            reset_latch_reg     <= reset_latch_next;
            error_pending_reg   <= error_pending_next;
            cleared_pending_reg <= cleared_pending_next;
        end
    end

    always_comb
    begin
        snap.active_mask  = active_bits_next;
        snap.live         = active_bits_next & known;
        snap.fault_index  = fault_index;
        snap.rank         = rank;
        snap.reset_needed = reset_latch_next;
        snap.error_sent   = error_sent;
        snap.cleared_sent = cleared_sent;
    end

endmodule

// ===== rtl/fsa_rank.sv =====
// Active count and rank lookup from per-byte population counts.
module fsa_rank (
    input  logic [fsa_pkg::SLOTS-1:0]  live,
    input  logic [fsa_pkg::SLOT_W-1:0] rank,
    input  fsa_pkg::byte_cnt_t         cnt,
    output fsa_pkg::rank_res_t         res
);

    logic [fsa_pkg::BYTES-1:0][fsa_pkg::COUNT_W-1:0] prefix;
    logic [fsa_pkg::COUNT_W-1:0] total;
    logic [fsa_pkg::COUNT_W-1:0] rank_w;
    logic [1:0]                  byte_sel;
    logic [fsa_pkg::COUNT_W-1:0] local_w;
    logic [2:0]                  local_rank;
    logic [7:0]                  byte_bits;
    logic [3:0]                  seen;
    logic [2:0]                  bit_pos;
    logic                        bit_hit;

    assign rank_w = fsa_pkg::COUNT_W'(rank);

    always_comb
    begin
        prefix[0] = '0;
        for (int b = 1; b < fsa_pkg::BYTES; b++)
        begin
            prefix[b] = prefix[b-1] + fsa_pkg::COUNT_W'(cnt[b-1]);
        end
        total = prefix[fsa_pkg::BYTES-1] + fsa_pkg::COUNT_W'(cnt[fsa_pkg::BYTES-1]);
    end

    // Highest byte whose prefix is at or below the rank holds the target bit
    always_comb
    begin
        byte_sel = '0;
        for (int b = 1; b < fsa_pkg::BYTES; b++)
        begin
            if (prefix[b] <= rank_w)
            begin
                byte_sel = 2'(b);
            end
        end
    end

    assign local_w    = rank_w - prefix[byte_sel];
    assign local_rank = local_w[2:0];
    assign byte_bits  = live[{byte_sel, 3'b000} +: 8];

    always_comb
    begin
        seen    = '0;
        bit_pos = '0;
        bit_hit = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (byte_bits[i] && !bit_hit && seen == {1'b0, local_rank})
            begin
                bit_hit = 1'b1;
                bit_pos = 3'(i);
            end
            seen = seen + 4'(byte_bits[i]);
        end
    end

    always_comb
    begin
        res.count = total;
        res.found = rank_w < total;
        res.fault = res.found ? {byte_sel, bit_pos} : '0;
    end

endmodule
